// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== rtl/cmt_pkg.sv =====
// Types and constants for the cluster membership table.
package cmt_pkg;

    // Command codes
    localparam logic [2:0] CMD_PROP_ADD   = 3'd0;
    localparam logic [2:0] CMD_PROP_REM   = 3'd1;
    localparam logic [2:0] CMD_COMMIT_ADD = 3'd2;
    localparam logic [2:0] CMD_COMMIT_REM = 3'd3;
    localparam logic [2:0] CMD_QUERY      = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NOT_LEADER  = 3'd1;
    localparam logic [2:0] ST_INVALID     = 3'd2;
    localparam logic [2:0] ST_LOG_REFUSED = 3'd3;
    localparam logic [2:0] ST_FULL        = 3'd4;

    localparam int CFG_W  = 5;
    localparam int NODE_W = 8;
    localparam int SIZE_W = 5;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [NODE_W-1:0] node_id;
        logic              is_leader;
        logic              log_ready;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic              entry_valid;
        logic              entry_is_add;
        logic [NODE_W-1:0] entry_node;
        logic              is_member;
        logic [SIZE_W-1:0] cluster_size;
        logic              transitioning;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_EXEC,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load;
        logic exec;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic loaded;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/cmt_datapath.sv =====
// Membership table, pending change, request checks and result register.
module cmt_datapath #(
    parameter int MAX_NODES = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cmt_pkg::CFG_W-1:0]   i_cfg_data,
    input  cmt_pkg::t_in_item           i_in_data,
    input  cmt_pkg::t_dp_cmd            i_cmd,
    output cmt_pkg::t_dp_stat           o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cmt_pkg::t_out_item          o_out_data
);

    localparam int IdW  = (ID_BITS < cmt_pkg::NODE_W) ? ID_BITS : cmt_pkg::NODE_W;
    localparam int CntW = $clog2(MAX_NODES + 1);

    logic [IdW-1:0]           r_tbl [MAX_NODES];
    logic [IdW-1:0]           n_tbl [MAX_NODES];
    logic [CntW-1:0]          r_count, n_count;
    logic                     r_loaded, n_loaded;
    logic                     r_pend_valid, n_pend_valid;
    logic [IdW-1:0]           r_pend_id, n_pend_id;
    logic                     r_pend_add, n_pend_add;
    logic [cmt_pkg::CFG_W-1:0] r_init_count;

    logic [2:0]               r_cmd;
    logic [IdW-1:0]           r_id;
    logic                     r_leader;
    logic                     r_log_ok;

    logic [2:0]               r_status, n_status;
    logic                     r_ev, n_ev;
    logic                     r_eadd, n_eadd;

    logic                     r_out_valid;
    cmt_pkg::t_out_item       r_out;

    logic [MAX_NODES-1:0]     w_match;
    logic [MAX_NODES-1:0]     w_after;
    logic                     w_present;
    logic [CntW-1:0]          w_load_n;
    logic [CntW:0]            w_size;

    // Parallel compare against the live part of the table
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            w_match[i] = (CntW'(i) < r_count) && (r_tbl[i] == r_id);
        end
        w_present = |w_match;
    end

    // Entries at or after the first match
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            w_after[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                w_after[i] = w_after[i] | w_match[j];
            end
        end
    end

    always_comb begin
        if (32'(r_init_count) > MAX_NODES) begin
            w_load_n = CntW'(MAX_NODES);
        end else begin
            w_load_n = CntW'(r_init_count);
        end
    end

    always_comb begin
        n_tbl        = r_tbl;
        n_count      = r_count;
        n_loaded     = r_loaded;
        n_pend_valid = r_pend_valid;
        n_pend_id    = r_pend_id;
        n_pend_add   = r_pend_add;
        n_status     = r_status;
        n_ev         = r_ev;
        n_eadd       = r_eadd;

        if (i_cmd.load) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                if (CntW'(i) < w_load_n) begin
                    n_tbl[i] = IdW'(i);
                end
            end
            n_count  = w_load_n;
            n_loaded = 1'b1;
        end

        if (i_cmd.exec) begin
            n_status = cmt_pkg::ST_OK;
            n_ev     = 1'b0;
            n_eadd   = 1'b0;
            priority case (r_cmd)
                cmt_pkg::CMD_PROP_ADD, cmt_pkg::CMD_PROP_REM: begin
                    priority if (!r_leader) begin
                        n_status = cmt_pkg::ST_NOT_LEADER;
                    end else if ((r_cmd == cmt_pkg::CMD_PROP_ADD) == w_present) begin
                        n_status = cmt_pkg::ST_INVALID;
                    end else if (r_pend_valid) begin
                        n_status = cmt_pkg::ST_INVALID;
                    end else if (!r_log_ok) begin
                        n_status = cmt_pkg::ST_LOG_REFUSED;
                    end else begin
                        n_ev         = 1'b1;
                        n_eadd       = (r_cmd == cmt_pkg::CMD_PROP_ADD);
                        n_pend_valid = 1'b1;
                        n_pend_id    = r_id;
                        n_pend_add   = (r_cmd == cmt_pkg::CMD_PROP_ADD);
                    end
                end
                cmt_pkg::CMD_COMMIT_ADD: begin
                    if (32'(r_count) < MAX_NODES) begin
                        for (int i = 0; i < MAX_NODES; i++) begin
                            if (r_count == CntW'(i)) begin
                                n_tbl[i] = r_id;
                            end
                        end
                        n_count = r_count + CntW'(1);
                    end else begin
                        n_status = cmt_pkg::ST_FULL;
                    end
                    n_pend_valid = 1'b0;
                    n_pend_id    = '0;
                    n_pend_add   = 1'b0;
                end
                cmt_pkg::CMD_COMMIT_REM: begin
                    // Close the gap: every entry from the match up to the second-to-last takes its upper neighbor
                    if (w_present) begin
                        for (int i = 0; i < MAX_NODES - 1; i++) begin
                            if (w_after[i]) begin
                                n_tbl[i] = r_tbl[i+1];
                            end
                        end
                        n_count = r_count - CntW'(1);
                    end
                    n_pend_valid = 1'b0;
                    n_pend_id    = '0;
                    n_pend_add   = 1'b0;
                end
                cmt_pkg::CMD_QUERY: begin
                    n_status = cmt_pkg::ST_OK;
                end
                default: begin
                    n_status = cmt_pkg::ST_INVALID;
                end
            endcase
        end
    end

    assign w_size = {1'b0, r_count} + (CntW+1)'(r_pend_valid && r_pend_add);

    always_ff @(posedge i_clk) begin
        r_tbl    <= n_tbl;
        r_status <= n_status;
        r_ev     <= n_ev;
        r_eadd   <= n_eadd;
        if (i_cmd.capture) begin
            r_cmd    <= i_in_data.cmd;
            r_id     <= IdW'(i_in_data.node_id);
            r_leader <= i_in_data.is_leader;
            r_log_ok <= i_in_data.log_ready;
        end
        if (i_cmd.finish) begin
            r_out.status        <= r_status;
            r_out.entry_valid   <= r_ev;
            r_out.entry_is_add  <= r_eadd;
            r_out.entry_node    <= r_ev ? cmt_pkg::NODE_W'(r_id) : '0;
            r_out.is_member     <= w_present ||
                                   (r_pend_valid && r_pend_add && (r_pend_id == r_id));
            r_out.cluster_size  <= cmt_pkg::SIZE_W'(w_size);
            r_out.transitioning <= r_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_loaded     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_id    <= '0;
            r_pend_add   <= 1'b0;
            r_init_count <= cmt_pkg::CFG_W'(3);
            r_out_valid  <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_loaded     <= n_loaded;
            r_pend_valid <= n_pend_valid;
            r_pend_id    <= n_pend_id;
            r_pend_add   <= n_pend_add;
            if (i_cfg_we) begin
                r_init_count <= i_cfg_data;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.loaded   = r_loaded;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

// ===== rtl/cmt_controller.sv =====
// Sequencing state machine: accept, load, execute, publish.
module cmt_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cmt_pkg::t_dp_stat  i_stat,
    output cmt_pkg::t_dp_cmd   o_cmd
);

    cmt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            cmt_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_stat.loaded ? cmt_pkg::S_EXEC : cmt_pkg::S_LOAD;
                end
            end
            cmt_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = cmt_pkg::S_EXEC;
            end
            cmt_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = cmt_pkg::S_FINISH;
            end
            cmt_pkg::S_FINISH: begin
                // Hold until the result register can take a new transaction
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = cmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cmt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cluster_membership_table.sv =====
// Top level of the cluster membership table.
// Cluster membership table: holds up to MAX_NODES voting node ids and at most
// one pending single-node change. Each input transaction yields exactly one
// result transaction. The first transaction after reset loads ids 0 upward,
// initial_node_count of them (capped at MAX_NODES), into the table. A proposal
// is checked for leadership, membership, an already pending change and log
// readiness, in that order; when it passes, a log entry is emitted and the
// change is marked pending. A commit appends the id (dropped with status full
// when the table is full) or removes the first match and closes the gap; both
// clear the pending change. Timing: the result register is written in the
// publish step after the capture and execute steps (with the table load
// step between them for the first transaction after reset), and the input
// opens again in the cycle after that write; the controller walks capture,
// load, execute and publish with the single shared compare array; one
// transaction is in flight at a time. The result register lets the next
// transaction be accepted while the previous result is still stalled;
// publishing waits until that register frees up.
// Write initial_node_count only while the block is idle; it takes effect at
// the first transaction after reset.
module cluster_membership_table #(
    parameter int MAX_NODES = 16,
    parameter int ID_BITS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [cmt_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  cmt_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output cmt_pkg::t_out_item         o_out_data
);

    cmt_pkg::t_dp_cmd  w_cmd;
    cmt_pkg::t_dp_stat w_stat;

    cmt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    cmt_datapath #(
        .MAX_NODES (MAX_NODES),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/cmt_checker.sv =====
// Port-level checks for the cluster membership table, bound to the top level.
`include "assert_macros.svh"

module cmt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cmt_pkg::t_out_item  o_out_data
);

    // An emitted entry only comes from a passing proposal, which leaves a change pending
    `ASSERT_IMPLIES(a_entry_ok, i_clk, i_rst_n, o_out_valid && o_out_data.entry_valid, o_out_data.status == cmt_pkg::ST_OK)
    `ASSERT_IMPLIES(a_entry_pending, i_clk, i_rst_n, o_out_valid && o_out_data.entry_valid, o_out_data.transitioning)
    // A commit always clears the pending change, also when the table is full
    `ASSERT_IMPLIES(a_full_cleared, i_clk, i_rst_n, o_out_valid && (o_out_data.status == cmt_pkg::ST_FULL), !o_out_data.transitioning)
    // One transaction in flight: an accept closes the input side
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind cluster_membership_table cmt_checker u_cmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
